/* hw/rtl/rog_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rog_pkg: shared types and constants for the random offset generator
// Holds the xorshift constants, the control state encoding, register
// indexes and the status struct passed from the modulo unit.
// ----------------------------------------------------------------------------
package rog_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 1;
    localparam int STEP_CNT_W = 6;

    localparam logic [WORD_W-1:0] SEED_OFFSET = 32'd123211;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 6;
    localparam int SHIFT_C = 11;
    localparam int SHIFT_D = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SIZE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_DIV,
        ST_OUT
    } rog_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = v;
        t = t ^ (t << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        t = t ^ (t >> SHIFT_D);
        return t;
    endfunction

endpackage

/* hw/rtl/random_offset_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_offset_generator_top: xorshift32 offset source with modulo range
// Sequencer, generator word, seeding multiplier and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Write seed_value (index 0) and device_size (index 1) on the cfg port
//   while idle. Each transfer on the s_ channel advances the generator
//   once; s_tdata[0] = 1 reseeds from the registers before the advance.
//   Each input transfer yields exactly one m_ transfer carrying the offset
//   (state modulo size), the raw state and a zero-size flag.
//
//   From input transfer to m_tvalid the block runs the seeding multiply
//   (restart only), a scramble step, the bit-serial modulo unit and a
//   register that captures the result.
//   The block takes one item at a time: s_tready stays low from the input
//   transfer until the result has been taken.
//
//   Reset clears the generator word and both registers; the word 0 is a
//   fixed point, so results stay 0 until a restart. A stalled receiver
//   holds the result and the input side stays blocked.
// ----------------------------------------------------------------------------
module random_offset_generator_top #(
    parameter int SIZE_BITS = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rog_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]          cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rog_pkg::S_TDATA_W-1:0] s_tdata,  // [0] restart, [7:1] zero
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rog_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] offset, [63:32] generator_state
    output logic [rog_pkg::M_TUSER_W-1:0] m_tuser   // [0] size_error
);
    import rog_pkg::*;

    rog_state_t        state_reg, state_next;
    logic [WORD_W-1:0] seed_value_reg;
    logic [SIZE_BITS-1:0] device_size_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] seed_scr_reg;
    logic [WORD_W-1:0] offset_reg;
    logic              err_reg;
    logic [2*WORD_W-1:0] prod_full;
    logic              s_xfer;
    logic              div_start;
    logic [WORD_W-1:0] div_rem;
    div_status_t       div_status;
    logic              size_zero;

    assign s_xfer    = s_tvalid && s_tready;
    assign prod_full = {{WORD_W{1'b0}}, seed_scr_reg} *
                       {{WORD_W{1'b0}}, device_size_reg[WORD_W-1:0]};
    assign size_zero = (device_size_reg == '0);

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_value_reg  <= '0;
            device_size_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SEED_VALUE) begin
                seed_value_reg <= cfg_wdata[WORD_W-1:0];
            end else if (cfg_index == CFG_DEVICE_SIZE) begin
                device_size_reg <= cfg_wdata;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = s_tdata[0] ? ST_SEED : ST_STEP;
                end
            end
            ST_SEED: state_next = ST_STEP;
            ST_STEP: state_next = ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_STEP: div_start = 1'b1;
            ST_OUT:  m_tvalid  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            word_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SEED) begin
                word_reg <= prod_full[WORD_W-1:0];
            end else if (state_reg == ST_STEP) begin
                word_reg <= xorshift32(word_reg);
            end
        end
        if (s_xfer) begin
            seed_scr_reg <= xorshift32(seed_value_reg + SEED_OFFSET);
        end
        if (div_status.done) begin
            offset_reg <= size_zero ? '0 : div_rem;
            err_reg    <= size_zero;
        end
    end

    rog_divider #(
        .SIZE_BITS (SIZE_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (xorshift32(word_reg)),
        .divisor   (device_size_reg),
        .remainder (div_rem),
        .status    (div_status)
    );

    assign m_tdata = {word_reg, offset_reg};
    assign m_tuser = {err_reg};

endmodule

/* hw/rtl/rog_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rog_divider: iterative 32-bit modulo unit
// Restoring division, one dividend bit per cycle through one shared
// compare and subtract; the remainder is valid when done pulses.
// ----------------------------------------------------------------------------
module rog_divider #(
    parameter int SIZE_BITS = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rog_pkg::WORD_W-1:0] dividend,
    input  logic [SIZE_BITS-1:0]       divisor,
    output logic [rog_pkg::WORD_W-1:0] remainder,
    output rog_pkg::div_status_t       status
);
    import rog_pkg::*;

    logic [SIZE_BITS-1:0]  rem_reg,  rem_next;
    logic [WORD_W-1:0]     dvd_reg,  dvd_next;
    logic [STEP_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SIZE_BITS:0]    trial;
    logic [SIZE_BITS:0]    diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = STEP_CNT_W'(WORD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the difference only when the divisor fits
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[SIZE_BITS-1:0];
            end else begin
                rem_next = trial[SIZE_BITS-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    // remainder never exceeds the 32-bit dividend
    assign remainder   = rem_reg[WORD_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hw/rtl/rog_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rog_checker: port-level assertions for the random offset generator
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module rog_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rog_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rog_pkg::M_TUSER_W-1:0] m_tuser
);
    import rog_pkg::*;

    // one item in flight: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a pending result blocks new input
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    a_hold_stalled_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // zero device size forces offset zero
    a_zero_size_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[WORD_W-1:0] == '0)
        else $error("nonzero offset with size error");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind random_offset_generator_top rog_checker u_rog_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
